### sv/frustum_aabb_culler_assert.svh
// Assertion macros used by the frustum culler top level.
`ifndef FRUSTUM_AABB_CULLER_ASSERT_SVH
`define FRUSTUM_AABB_CULLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/fac_pkg.sv
// Shared types and constants of the frustum culler.
`default_nettype none
package fac_pkg;
	localparam int COORD_FRAC_BITS = 16;
	localparam int ACC_W = 100;
	localparam int NUM_PLANES = 6;

	localparam logic [1:0] KIND_LOAD_PROJ = 2'd0;
	localparam logic [1:0] KIND_LOAD_VIEW = 2'd1;
	localparam logic [1:0] KIND_EXTRACT = 2'd2;
	localparam logic [1:0] KIND_TEST = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_X_RD,
		S_X_DIF,
		S_X_MUL,
		S_X_ACC,
		S_X_WR,
		S_T_INIT,
		S_T_MUL,
		S_T_LAST,
		S_T_CHK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic mul_hi;
		logic acc_init;
		logic acc_add;
	} mac_ctl_t;
endpackage
`default_nettype wire

### sv/fac_mac.sv
// Shared multiply-accumulate unit: one 33x33 signed multiplier and a wide accumulator.
`default_nettype none
module fac_mac (
	input  wire logic                             clk,
	input  wire fac_pkg::mac_ctl_t                ctl,
	input  wire logic signed [32:0]               op_a,
	input  wire logic signed [32:0]               op_b,
	input  wire logic signed [fac_pkg::ACC_W-1:0] init_val,
	output logic signed [fac_pkg::ACC_W-1:0]      acc
);
	logic signed [65:0]               prod_s1;
	logic                             hi_s1;
	logic signed [fac_pkg::ACC_W-1:0] addend;
	logic signed [fac_pkg::ACC_W-1:0] acc_q;

	// register the product before it reaches the adder
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= op_a * op_b;
			hi_s1 <= ctl.mul_hi;
		end
	end

	always_comb begin
		addend = fac_pkg::ACC_W'(prod_s1);
		if (hi_s1) begin
			addend = addend <<< 32;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_init) begin
			acc_q <= init_val;
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

### sv/frustum_aabb_culler.sv
// Top level of the frustum culler: matrix stores, plane store, sequencer and shared MAC.
//
//  channel | signals                              | direction | transfer when
//  in      | in_valid in_ready kind .. box_max_z  | into      | in_valid & in_ready
//  out     | out_valid out_ready culled           | out of    | out_valid & out_ready
//
// A load item writes one element to its matrix store. An extract item runs 96 multiply-accumulates
// on the shared multiplier, each via read, difference, multiply and accumulate states, plus a write
// per plane component. A test item with a box runs init, six multiply, last-add and check steps per plane
// (just init for a zero normal), stops at a culling plane, then waits for the result transfer.
// Reset clears the matrix and plane stores at once; no clearing pass.
// A stalled result holds the block: no input is taken until it is transferred.
`default_nettype none
`include "frustum_aabb_culler_assert.svh"
module frustum_aabb_culler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [3:0]         element_index,
	input  wire logic signed [31:0] element_value,
	input  wire logic               has_box,
	input  wire logic signed [31:0] box_min_x,
	input  wire logic signed [31:0] box_min_y,
	input  wire logic signed [31:0] box_min_z,
	input  wire logic signed [31:0] box_max_x,
	input  wire logic signed [31:0] box_max_y,
	input  wire logic signed [31:0] box_max_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    culled
);
	fac_pkg::state_t state_q, state_nx;

	logic [31:0] proj_q [16];
	logic [31:0] view_q [16];
	logic [63:0] plane_q [fac_pkg::NUM_PLANES][4];

	logic [2:0] pl_q;
	logic [1:0] comp_q;
	logic [1:0] m_q;
	logic [2:0] k_q;
	logic       culled_q;

	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];
	logic signed [31:0] p3_q;
	logic signed [31:0] v_q;
	logic signed [32:0] diff_q;

	logic               in_xfer;
	logic               out_xfer;
	logic [3:0]         proj_addr;
	logic [31:0]        proj_rd;
	logic [63:0]        row [4];
	logic               normal_zero;
	logic [1:0]         tc;
	logic [63:0]        pv;
	logic               pos;
	logic signed [31:0] coord;
	logic               last_pl;

	fac_pkg::mac_ctl_t                mac_ctl;
	logic signed [32:0]               op_a;
	logic signed [32:0]               op_b;
	logic signed [fac_pkg::ACC_W-1:0] init_val;
	logic signed [fac_pkg::ACC_W-1:0] acc;
	logic [63:0]                      sat;

	assign in_xfer = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign last_pl = (pl_q == 3'(fac_pkg::NUM_PLANES - 1));

	// one read of the projection store a cycle: row 3 first, then the plane's axis row
	assign proj_addr = (state_q == fac_pkg::S_X_RD) ? {m_q, 2'd3} : {m_q, pl_q[2:1]};
	assign proj_rd = proj_q[proj_addr];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			row[i] = plane_q[pl_q][i];
		end
	end
	assign normal_zero = (row[0] == '0) && (row[1] == '0) && (row[2] == '0);

	// corner selection for the component under test
	assign tc = k_q[2:1];
	assign pv = row[tc];
	assign pos = (pv != '0) && !pv[63];
	assign coord = pos ? bmax_q[tc] : bmin_q[tc];

	// saturate the accumulator to signed Q32.32
	always_comb begin
		if ((&acc[fac_pkg::ACC_W-1:63]) || !(|acc[fac_pkg::ACC_W-1:63])) begin
			sat = acc[63:0];
		end else if (acc[fac_pkg::ACC_W-1]) begin
			sat = {1'b1, 63'd0};
		end else begin
			sat = {1'b0, {63{1'b1}}};
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			fac_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						fac_pkg::KIND_EXTRACT: state_nx = fac_pkg::S_X_RD;
						fac_pkg::KIND_TEST: state_nx = has_box ? fac_pkg::S_T_INIT
							: fac_pkg::S_OUT;
						default: state_nx = fac_pkg::S_IDLE;
					endcase
				end
			end
			fac_pkg::S_X_RD: state_nx = fac_pkg::S_X_DIF;
			fac_pkg::S_X_DIF: state_nx = fac_pkg::S_X_MUL;
			fac_pkg::S_X_MUL: state_nx = fac_pkg::S_X_ACC;
			fac_pkg::S_X_ACC: state_nx = (m_q == 2'd3) ? fac_pkg::S_X_WR : fac_pkg::S_X_RD;
			fac_pkg::S_X_WR: begin
				state_nx = (last_pl && comp_q == 2'd3) ? fac_pkg::S_IDLE : fac_pkg::S_X_RD;
			end
			fac_pkg::S_T_INIT: begin
				if (!normal_zero) begin
					state_nx = fac_pkg::S_T_MUL;
				end else if (last_pl) begin
					state_nx = fac_pkg::S_OUT;
				end
			end
			fac_pkg::S_T_MUL: state_nx = (k_q == 3'd5) ? fac_pkg::S_T_LAST : fac_pkg::S_T_MUL;
			fac_pkg::S_T_LAST: state_nx = fac_pkg::S_T_CHK;
			fac_pkg::S_T_CHK: begin
				state_nx = (acc[fac_pkg::ACC_W-1] || last_pl) ? fac_pkg::S_OUT
					: fac_pkg::S_T_INIT;
			end
			fac_pkg::S_OUT: state_nx = out_ready ? fac_pkg::S_IDLE : fac_pkg::S_OUT;
			default: state_nx = fac_pkg::S_IDLE;
		endcase
	end

	// outputs and MAC control
	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		mac_ctl = '0;
		op_a = diff_q;
		op_b = 33'(v_q);
		init_val = '0;
		unique case (state_q)
			fac_pkg::S_IDLE: in_ready = 1'b1;
			fac_pkg::S_X_RD: mac_ctl.acc_init = (m_q == 2'd0);
			fac_pkg::S_X_MUL: mac_ctl.mul_en = 1'b1;
			fac_pkg::S_X_ACC: mac_ctl.acc_add = 1'b1;
			fac_pkg::S_T_INIT: begin
				mac_ctl.acc_init = 1'b1;
				init_val = fac_pkg::ACC_W'($signed(row[3])) <<< fac_pkg::COORD_FRAC_BITS;
			end
			fac_pkg::S_T_MUL: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.mul_hi = k_q[0];
				mac_ctl.acc_add = (k_q != 3'd0);
				op_a = k_q[0] ? 33'($signed(pv[63:32])) : $signed({1'b0, pv[31:0]});
				op_b = 33'(coord);
			end
			fac_pkg::S_T_LAST: mac_ctl.acc_add = 1'b1;
			fac_pkg::S_OUT: out_valid = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fac_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// hold the matrix and plane stores; reset clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				proj_q[i] <= '0;
				view_q[i] <= '0;
			end
			for (int p = 0; p < fac_pkg::NUM_PLANES; p++) begin
				for (int c = 0; c < 4; c++) begin
					plane_q[p][c] <= '0;
				end
			end
		end else begin
			if (in_xfer && kind == fac_pkg::KIND_LOAD_PROJ) begin
				proj_q[element_index] <= element_value;
			end
			if (in_xfer && kind == fac_pkg::KIND_LOAD_VIEW) begin
				view_q[element_index] <= element_value;
			end
			if (state_q == fac_pkg::S_X_WR) begin
				plane_q[pl_q][comp_q] <= sat;
			end
		end
	end

	// sequencer counters and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q <= '0;
			comp_q <= '0;
			m_q <= '0;
			k_q <= '0;
			culled_q <= 1'b0;
		end else begin
			unique case (state_q)
				fac_pkg::S_IDLE: begin
					pl_q <= '0;
					comp_q <= '0;
					m_q <= '0;
					k_q <= '0;
					culled_q <= 1'b0;
				end
				fac_pkg::S_X_ACC: m_q <= m_q + 2'd1;
				fac_pkg::S_X_WR: begin
					comp_q <= comp_q + 2'd1;
					if (comp_q == 2'd3) begin
						pl_q <= pl_q + 3'd1;
					end
				end
				fac_pkg::S_T_INIT: begin
					k_q <= '0;
					if (normal_zero && !last_pl) begin
						pl_q <= pl_q + 3'd1;
					end
				end
				fac_pkg::S_T_MUL: k_q <= k_q + 3'd1;
				fac_pkg::S_T_CHK: begin
					culled_q <= acc[fac_pkg::ACC_W-1];
					if (!acc[fac_pkg::ACC_W-1] && !last_pl) begin
						pl_q <= pl_q + 3'd1;
					end
				end
				default: pl_q <= pl_q;
			endcase
		end
	end

	// payload registers: box corners and extract operands
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			bmin_q[0] <= box_min_x;
			bmin_q[1] <= box_min_y;
			bmin_q[2] <= box_min_z;
			bmax_q[0] <= box_max_x;
			bmax_q[1] <= box_max_y;
			bmax_q[2] <= box_max_z;
		end
		if (state_q == fac_pkg::S_X_RD) begin
			p3_q <= proj_rd;
			v_q <= view_q[{comp_q, m_q}];
		end
		if (state_q == fac_pkg::S_X_DIF) begin
			diff_q <= pl_q[0] ? (33'(p3_q) - 33'($signed(proj_rd)))
				: (33'(p3_q) + 33'($signed(proj_rd)));
		end
	end

	fac_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.op_a    (op_a),
		.op_b    (op_b),
		.init_val(init_val),
		.acc     (acc)
	);

	assign culled = culled_q;

	`FAC_ASSERT_IMP(a_ready_excl, in_ready, !out_valid, "input taken while result pending")
	`FAC_ASSERT_NXT(a_nobox, in_xfer && kind == fac_pkg::KIND_TEST && !has_box, out_valid && !culled, "box-less item culled")
	`FAC_ASSERT_IMP(a_pl_range, state_q != fac_pkg::S_IDLE, pl_q < 3'(fac_pkg::NUM_PLANES), "plane counter out of range")
	`FAC_ASSERT_NXT(a_out_done, out_xfer, in_ready, "no return to idle after transfer")
endmodule
`default_nettype wire
